@@ rtl/cfar_pkg.sv @@
`timescale 1ns / 1ps
package cfar_pkg;

  localparam int MAX_COLS   = 1024;
  localparam int MAX_ROWS   = 1024;
  localparam int MAX_WINDOW = 9;
  localparam int HMAX       = (MAX_WINDOW - 1) / 2;

  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int SLOT_W = $clog2(MAX_WINDOW);
  localparam int H_W    = $clog2(HMAX + 1);
  localparam int DIM_W  = 11;
  localparam int CNT_W  = $clog2(MAX_WINDOW * MAX_WINDOW + 1);

  localparam int Q_DEPTH   = 4;
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);
  localparam int OUT_DEPTH = 8;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);

  // floor(x/100) for x < 2^13 as (x * 5243) >> 19
  localparam int PROD_W     = 13;
  localparam int RANK_MUL   = 5243;
  localparam int RANK_SHIFT = 19;
  localparam int RANK_W     = 7;

  localparam logic [2:0] REG_MAP_ROWS   = 3'd0;
  localparam logic [2:0] REG_MAP_COLS   = 3'd1;
  localparam logic [2:0] REG_WINDOW     = 3'd2;
  localparam logic [2:0] REG_GUARD      = 3'd3;
  localparam logic [2:0] REG_PERCENT    = 3'd4;
  localparam logic [2:0] REG_THRESHOLD  = 3'd5;

  typedef struct packed {
    logic [15:0] val;
    logic [11:0] col;
    logic [11:0] row;
  } cell_t;

  localparam int CELL_W = $bits(cell_t);

  typedef struct packed {
    cell_t             pix;
    logic [COL_W-1:0]  col;
    logic [SLOT_W-1:0] slot;
    logic              test;
  } item_t;

  typedef struct packed {
    logic [DIM_W-1:0]  rows;
    logic [DIM_W-1:0]  cols;
    logic [H_W-1:0]    h;
    logic [H_W-1:0]    g;
    logic [15:0]       thr;
    logic [RANK_W-1:0] rank;
  } cfg_t;

endpackage

@@ rtl/cfar_in_if.sv @@
`timescale 1ns / 1ps
interface cfar_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] corr_value;
  logic [11:0] col_tag;
  logic [11:0] row_tag;

  modport source (output valid, corr_value, col_tag, row_tag, input ready);
  modport sink (input valid, corr_value, col_tag, row_tag, output ready);
endinterface

@@ rtl/cfar_out_if.sv @@
`timescale 1ns / 1ps
interface cfar_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] det_col;
  logic [11:0] det_row;
  logic [15:0] det_value;

  modport source (output valid, det_col, det_row, det_value, input ready);
  modport sink (input valid, det_col, det_row, det_value, output ready);
endinterface

@@ rtl/cfar_ram.sv @@
`timescale 1ns / 1ps
module cfar_ram #(
  parameter int Width = 40,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ rtl/cfar_front.sv @@
`timescale 1ns / 1ps
module cfar_front import cfar_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  cfar_in_if.sink   sample_i,
  output logic      item_valid_o,
  output item_t     item_o,
  input  logic      item_pop_i
);

  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [SLOT_W-1:0] slot_q, slot_d;

  logic [DIM_W-1:0]  c0, r0, c1, r1;
  logic [SLOT_W-1:0] s0, s1;
  logic [DIM_W-1:0]  span;
  item_t             item_new;

  item_t             q_mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_q, rd_q;
  logic [Q_PTR_W:0]   cnt_q;
  logic               push;

  assign sample_i.ready = (cnt_q != (Q_PTR_W+1)'(Q_DEPTH));
  assign push = sample_i.valid && sample_i.ready;

  // raster position, with wrap for a map shrunk mid-frame
  always_comb begin
    c0 = DIM_W'(col_q);
    r0 = DIM_W'(row_q);
    s0 = slot_q;
    if (c0 >= cfg_i.cols) begin
      c0 = '0;
      r0 = r0 + 1'b1;
      s0 = (s0 == SLOT_W'(MAX_WINDOW - 1)) ? '0 : s0 + 1'b1;
    end
    if (r0 >= cfg_i.rows) begin
      r0 = '0;
      s0 = '0;
    end
    c1 = c0 + 1'b1;
    r1 = r0;
    s1 = s0;
    if (c1 >= cfg_i.cols) begin
      c1 = '0;
      r1 = r0 + 1'b1;
      s1 = (s0 == SLOT_W'(MAX_WINDOW - 1)) ? '0 : s0 + 1'b1;
      if (r1 >= cfg_i.rows) begin
        r1 = '0;
        s1 = '0;
      end
    end
    col_d = c1[COL_W-1:0];
    row_d = r1[ROW_W-1:0];
    slot_d = s1;
    span = DIM_W'({cfg_i.h, 1'b0});
    item_new.pix.val = sample_i.corr_value;
    item_new.pix.col = sample_i.col_tag;
    item_new.pix.row = sample_i.row_tag;
    item_new.col = c0[COL_W-1:0];
    item_new.slot = s0;
    item_new.test = (r0 >= span) && (c0 >= span);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      slot_q <= '0;
    end else if (push) begin
      col_q <= col_d;
      row_q <= row_d;
      slot_q <= slot_d;
    end
  end

  // short queue to the back end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (item_pop_i) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (Q_PTR_W+1)'(push) - (Q_PTR_W+1)'(item_pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wr_q] <= item_new;
  end

  assign item_valid_o = (cnt_q != '0);
  assign item_o = q_mem[rd_q];

endmodule

@@ rtl/cfar_back.sv @@
`timescale 1ns / 1ps
module cfar_back import cfar_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      item_valid_i,
  input  item_t     item_i,
  output logic      item_pop_o,
  cfar_out_if.source det_o
);

  localparam int NW = MAX_WINDOW;

  // line buffer: one RAM per ring slot
  logic [CELL_W-1:0] ram_rd [NW];
  logic              pop;
  logic              v1_q, v2_q, v3_q, v4_q;
  item_t             it1_q;
  logic              test2_q;

  cell_t             col_cells [NW];
  cell_t             win_q [NW][NW];

  cell_t             centre;
  logic [NW-1:0]     gt [NW];
  logic [NW-1:0]     gt3_q [NW];
  cell_t             centre3_q, centre4_q;
  logic              hit3_q, hit4_q;
  logic [SLOT_W-1:0] part [NW];
  logic [SLOT_W-1:0] part4_q [NW];
  logic [CNT_W-1:0]  total;
  logic              det_push;

  cell_t              out_mem [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] owr_q, ord_q;
  logic [OUT_PTR_W:0]   ocnt_q;
  logic [OUT_PTR_W:0]   inflight;
  logic                 det_pop;

  // pop only with room reserved for every beat still in flight
  assign inflight = (OUT_PTR_W+1)'(v1_q) + (OUT_PTR_W+1)'(v2_q)
                  + (OUT_PTR_W+1)'(v3_q) + (OUT_PTR_W+1)'(v4_q);
  assign pop = item_valid_i &&
               ((ocnt_q + inflight) < (OUT_PTR_W+1)'(OUT_DEPTH));
  assign item_pop_o = pop;

  for (genvar k = 0; k < NW; k++) begin : g_line
    cfar_ram #(.Width(CELL_W), .Depth(MAX_COLS)) u_ram (
      .clk_i   (clk_i),
      .we_i    (pop && (item_i.slot == SLOT_W'(k))),
      .waddr_i (item_i.col),
      .wdata_i (item_i.pix),
      .raddr_i (item_i.col),
      .rdata_o (ram_rd[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= pop;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) it1_q <= item_i;
    if (v1_q) test2_q <= it1_q.test;
  end

  // column of the current sample, newest row first
  always_comb begin
    col_cells[0] = it1_q.pix;
    for (int dy = 1; dy < NW; dy++) begin
      if (it1_q.slot >= SLOT_W'(dy)) begin
        col_cells[dy] = cell_t'(ram_rd[it1_q.slot - SLOT_W'(dy)]);
      end else begin
        col_cells[dy] = cell_t'(ram_rd[it1_q.slot + SLOT_W'(NW - dy)]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      for (int dy = 0; dy < NW; dy++) begin
        win_q[dy][0] <= col_cells[dy];
        for (int dx = 1; dx < NW; dx++) begin
          win_q[dy][dx] <= win_q[dy][dx-1];
        end
      end
    end
  end

  // training cells that beat the centre
  assign centre = win_q[SLOT_W'(cfg_i.h)][SLOT_W'(cfg_i.h)];

  always_comb begin
    logic [SLOT_W-1:0] hh, span, gg, oy, ox;
    hh = SLOT_W'(cfg_i.h);
    gg = SLOT_W'(cfg_i.g);
    span = SLOT_W'({cfg_i.h, 1'b0});
    for (int dy = 0; dy < NW; dy++) begin
      oy = (SLOT_W'(dy) > hh) ? SLOT_W'(dy) - hh : hh - SLOT_W'(dy);
      for (int dx = 0; dx < NW; dx++) begin
        ox = (SLOT_W'(dx) > hh) ? SLOT_W'(dx) - hh : hh - SLOT_W'(dx);
        gt[dy][dx] = (SLOT_W'(dy) <= span) && (SLOT_W'(dx) <= span) &&
                     !((oy <= gg) && (ox <= gg)) &&
                     ($signed(win_q[dy][dx].val) > $signed(centre.val));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (v2_q) begin
      gt3_q <= gt;
      centre3_q <= centre;
      hit3_q <= test2_q && ($signed(centre.val) < $signed(cfg_i.thr));
    end
  end

  always_comb begin
    for (int dy = 0; dy < NW; dy++) begin
      part[dy] = '0;
      for (int dx = 0; dx < NW; dx++) begin
        part[dy] = part[dy] + SLOT_W'(gt3_q[dy][dx]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (v3_q) begin
      part4_q <= part;
      centre4_q <= centre3_q;
      hit4_q <= hit3_q;
    end
  end

  always_comb begin
    total = '0;
    for (int dy = 0; dy < NW; dy++) begin
      total = total + CNT_W'(part4_q[dy]);
    end
  end

  assign det_push = v4_q && hit4_q && (total >= CNT_W'(cfg_i.rank));

  // result queue
  assign det_pop = det_o.valid && det_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owr_q <= '0;
      ord_q <= '0;
      ocnt_q <= '0;
    end else begin
      if (det_push) owr_q <= owr_q + 1'b1;
      if (det_pop) ord_q <= ord_q + 1'b1;
      ocnt_q <= ocnt_q + (OUT_PTR_W+1)'(det_push) - (OUT_PTR_W+1)'(det_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (det_push) out_mem[owr_q] <= centre4_q;
  end

  assign det_o.valid = (ocnt_q != '0);
  assign det_o.det_col = out_mem[ord_q].col;
  assign det_o.det_row = out_mem[ord_q].row;
  assign det_o.det_value = out_mem[ord_q].val;

endmodule

@@ rtl/cfar_window_detector.sv @@
`timescale 1ns / 1ps
// Rank CFAR detector over a raster-order correlation map. One sample beat is
// taken per clock while the input queue has room, and line buffers (one
// 1024-entry RAM per window row) feed a 9x9 window of registers; a centre
// cell is flagged when its value is below corr_threshold and enough training
// cells outside the guard square are strictly larger. A detection passes the
// input queue, the line buffer read and the window, compare and count
// registers and the result queue before it leaves the output. Output stalls
// back up through an 8-deep result queue and a 4-deep input queue. The user
// must write configuration only while idle; the block does not enforce it.
// The required rank count settles through prod_q and rank_q after a write.
module cfar_window_detector import cfar_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  cfar_in_if.sink    sample_i,
  cfar_out_if.source det_o
);

  logic [DIM_W-1:0] rows_q, cols_q;
  logic [3:0]       win_q;
  logic [2:0]       guard_q;
  logic [6:0]       pct_q;
  logic [15:0]      thr_q;
  logic [PROD_W-1:0] prod_q;
  logic [RANK_W-1:0] rank_q;

  logic [2:0]       hr, gr;
  logic [H_W-1:0]   h, g;
  logic [3:0]       w_side, g_side;
  logic [6:0]       diff, pct;
  logic [PROD_W+PROD_W-1:0] scaled;
  cfg_t             cfg;
  logic             item_valid, item_pop;
  item_t            item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= DIM_W'(256);
      cols_q <= DIM_W'(256);
      win_q <= 4'd5;
      guard_q <= 3'd3;
      pct_q <= 7'd50;
      thr_q <= 16'd29491;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MAP_ROWS:  rows_q <= cfg_data_i[DIM_W-1:0];
        REG_MAP_COLS:  cols_q <= cfg_data_i[DIM_W-1:0];
        REG_WINDOW:    win_q <= cfg_data_i[3:0];
        REG_GUARD:     guard_q <= cfg_data_i[2:0];
        REG_PERCENT:   pct_q <= cfg_data_i[6:0];
        REG_THRESHOLD: thr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // effective radii: window clamped to 1..HMAX, guard below window
  always_comb begin
    hr = (win_q == '0) ? 3'd0 : 3'((win_q - 4'd1) >> 1);
    if (hr < 3'd1) h = H_W'(1);
    else if (hr > 3'(HMAX)) h = H_W'(HMAX);
    else h = H_W'(hr);
    gr = (guard_q == '0) ? 3'd0 : ((guard_q - 3'd1) >> 1);
    g = (H_W'(gr) > h - 1'b1) ? h - 1'b1 : H_W'(gr);
    w_side = {h, 1'b1};
    g_side = {g, 1'b1};
    diff = 7'(w_side * w_side) - 7'(g_side * g_side);
    pct = (pct_q > 7'd100) ? 7'd100 : pct_q;
    scaled = prod_q * PROD_W'(RANK_MUL);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q <= PROD_W'(800);
      rank_q <= RANK_W'(8);
    end else begin
      prod_q <= PROD_W'(pct * diff);
      rank_q <= scaled[RANK_SHIFT +: RANK_W];
    end
  end

  always_comb begin
    cfg.rows = (rows_q == '0) ? DIM_W'(1) :
               (rows_q > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : rows_q;
    cfg.cols = (cols_q == '0) ? DIM_W'(1) :
               (cols_q > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : cols_q;
    cfg.h = h;
    cfg.g = g;
    cfg.thr = thr_q;
    cfg.rank = rank_q;
  end

  cfar_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .sample_i     (sample_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  cfar_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .det_o        (det_o)
  );

endmodule

@@ rtl/cfar_chk.sv @@
`timescale 1ns / 1ps
module cfar_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        det_valid_i,
  input logic        det_ready_i,
  input logic [11:0] det_col_i,
  input logic [11:0] det_row_i,
  input logic [15:0] det_value_i
);

  // result queue is empty while in reset
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !det_valid_i)
    else $error("detection shown during reset");

  // no detection can surface in the first clocks after reset
  a_start_latency: assert property (@(posedge clk_i)
      $rose(rst_ni) |-> !det_valid_i ##1 !det_valid_i)
    else $error("detection too soon after reset");

  // stalled beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
      det_valid_i && !det_ready_i |=> det_valid_i && $stable(det_col_i) &&
      $stable(det_row_i) && $stable(det_value_i))
    else $error("stalled detection beat changed");

endmodule

bind cfar_window_detector cfar_chk u_cfar_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .det_valid_i (det_o.valid),
  .det_ready_i (det_o.ready),
  .det_col_i   (det_o.det_col),
  .det_row_i   (det_o.det_row),
  .det_value_i (det_o.det_value)
);
